// File: rtl/core/ethip_pkg.sv
// ----------------------------------------------------------------------------
// ethip_pkg
// Types and constants shared by the Ethernet/IPv4 header parser modules.
// ----------------------------------------------------------------------------
package ethip_pkg;

	localparam logic [15:0] ETH_HDR_BYTES   = 16'd14;
	localparam logic [15:0] IPV4_MIN_BYTES  = 16'd20;
	localparam logic [15:0] TCP_MIN_BYTES   = 16'd20;
	localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;
	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
	localparam logic [15:0] POS_MAX         = 16'hFFFF;
	localparam logic [7:0]  PROTO_ICMP      = 8'd1;
	localparam logic [7:0]  PROTO_TCP       = 8'd6;
	localparam logic [7:0]  PROTO_UDP       = 8'd17;
	localparam logic [7:0]  ICMP_ECHO_REQ   = 8'd8;
	localparam logic [7:0]  ICMP_ECHO_REP   = 8'd0;

	// header byte positions within the frame
	localparam logic [15:0] POS_ETYPE_HI    = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO    = 16'd13;
	localparam logic [15:0] POS_IHL         = 16'd14;
	localparam logic [15:0] POS_TTL         = 16'd22;
	localparam logic [15:0] POS_PROTO       = 16'd23;
	localparam logic [15:0] POS_SRC_FIRST   = 16'd26;
	localparam logic [15:0] POS_SRC_LAST    = 16'd29;
	localparam logic [15:0] POS_DST_FIRST   = 16'd30;
	localparam logic [15:0] POS_DST_LAST    = 16'd33;
	// offsets within the transport header
	localparam logic [15:0] TI_PORTS_END    = 16'd4;
	localparam logic [15:0] TI_DOFF         = 16'd12;
	localparam logic [15:0] TI_FLAGS        = 16'd13;

	// configuration register indexes
	localparam logic [1:0] REG_HTTP_PORT  = 2'd0;
	localparam logic [1:0] REG_HTTPS_PORT = 2'd1;
	localparam logic [1:0] REG_DNS_PORT   = 2'd2;

	localparam logic [15:0] HTTP_PORT_RST  = 16'd80;
	localparam logic [15:0] HTTPS_PORT_RST = 16'd443;
	localparam logic [15:0] DNS_PORT_RST   = 16'd53;

	typedef enum logic [2:0] {
		CLS_UNKNOWN = 3'd0,
		CLS_TCP     = 3'd1,
		CLS_UDP     = 3'd2,
		CLS_ICMP    = 3'd3,
		CLS_DNS     = 3'd4,
		CLS_HTTP    = 3'd5,
		CLS_HTTPS   = 3'd6
	} ethip_class_t;

	typedef enum logic [1:0] {
		ICMP_NONE  = 2'd0,
		ICMP_REQ   = 2'd1,
		ICMP_REP   = 2'd2,
		ICMP_OTHER = 2'd3
	} ethip_icmp_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} ethip_in_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  protocol_class;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [7:0]  time_to_live;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [4:0]  tcp_flag_bits;
		logic [1:0]  icmp_kind;
		logic [15:0] frame_length;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} ethip_out_t;

	// captured header state of one finished frame
	typedef struct packed {
		logic [15:0] len;
		logic [15:0] ether_kind;
		logic [5:0]  ihl_bytes;
		logic [7:0]  proto;
		logic [7:0]  ttl;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] ports;
		logic [5:0]  doff_bytes;
		logic [4:0]  flags;
		logic [7:0]  icmp_type;
	} ethip_rec_t;

	// port match bits: [0] http, [1] https, [2] dns
	function automatic ethip_class_t ethip_match(input logic [2:0] m);
		ethip_class_t c;
		priority if (m[0]) c = CLS_HTTP;
		else if (m[1])     c = CLS_HTTPS;
		else if (m[2])     c = CLS_DNS;
		else               c = CLS_UNKNOWN;
		return c;
	endfunction

	function automatic ethip_class_t ethip_classify(input logic [2:0] m_dp,
			input logic [2:0] m_sp, input ethip_class_t fallback);
		ethip_class_t c;
		priority if (m_dp != 3'b000) c = ethip_match(m_dp);
		else if (m_sp != 3'b000)     c = ethip_match(m_sp);
		else                         c = fallback;
		return c;
	endfunction

endpackage

// File: rtl/core/ethip_front.sv
// ----------------------------------------------------------------------------
// ethip_front
// Byte position counter and header field capture; pushes one record per frame.
// ----------------------------------------------------------------------------
module ethip_front import ethip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  ethip_in_t  beat,
	output logic       push,
	output ethip_rec_t push_rec
);

	logic [15:0] pos_q, ether_q, ether_n;
	logic [5:0]  ihl_q, ihl_n, doff_q, doff_n;
	logic [7:0]  proto_q, proto_n, ttl_q, ttl_n, icmp_q, icmp_n;
	logic [31:0] src_q, src_n, dst_q, dst_n, ports_q, ports_n;
	logic [4:0]  flags_q, flags_n;
	logic [15:0] ti, tr_start, len;
	logic        in_tr;
	logic [7:0]  b;

	assign b = beat.data_byte;

	always_comb begin
		ether_n = ether_q;
		if (pos_q == POS_ETYPE_HI) ether_n[15:8] = b;
		if (pos_q == POS_ETYPE_LO) ether_n[7:0] = b;
		ihl_n   = (pos_q == POS_IHL) ? {b[3:0], 2'b00} : ihl_q;
		ttl_n   = (pos_q == POS_TTL) ? b : ttl_q;
		proto_n = (pos_q == POS_PROTO) ? b : proto_q;
		src_n   = (pos_q >= POS_SRC_FIRST && pos_q <= POS_SRC_LAST) ?
			{src_q[23:0], b} : src_q;
		dst_n   = (pos_q >= POS_DST_FIRST && pos_q <= POS_DST_LAST) ?
			{dst_q[23:0], b} : dst_q;

		// transport header starts right after the IPv4 header (IHL as given)
		tr_start = ETH_HDR_BYTES + {10'd0, ihl_n};
		in_tr    = (pos_q >= tr_start);
		ti       = pos_q - tr_start;
		icmp_n   = (in_tr && ti == 16'd0) ? b : icmp_q;
		ports_n  = (in_tr && ti < TI_PORTS_END) ? {ports_q[23:0], b} : ports_q;
		doff_n   = (in_tr && ti == TI_DOFF) ? {b[7:4], 2'b00} : doff_q;
		flags_n  = (in_tr && ti == TI_FLAGS) ? b[4:0] : flags_q;

		len = (pos_q == POS_MAX) ? POS_MAX : pos_q + 16'd1;
	end

	assign push = accept && beat.last_byte;

	always_comb begin
		push_rec.len        = len;
		push_rec.ether_kind = ether_n;
		push_rec.ihl_bytes  = ihl_n;
		push_rec.proto      = proto_n;
		push_rec.ttl        = ttl_n;
		push_rec.src        = src_n;
		push_rec.dst        = dst_n;
		push_rec.ports      = ports_n;
		push_rec.doff_bytes = doff_n;
		push_rec.flags      = flags_n;
		push_rec.icmp_type  = icmp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ether_q <= '0;
			ihl_q   <= '0;
			proto_q <= '0;
			ttl_q   <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			ports_q <= '0;
			doff_q  <= '0;
			flags_q <= '0;
			icmp_q  <= '0;
		end else if (accept) begin
			if (beat.last_byte) begin
				pos_q   <= '0;
				ether_q <= '0;
				ihl_q   <= '0;
				proto_q <= '0;
				ttl_q   <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				ports_q <= '0;
				doff_q  <= '0;
				flags_q <= '0;
				icmp_q  <= '0;
			end else begin
				pos_q   <= len;
				ether_q <= ether_n;
				ihl_q   <= ihl_n;
				proto_q <= proto_n;
				ttl_q   <= ttl_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
				ports_q <= ports_n;
				doff_q  <= doff_n;
				flags_q <= flags_n;
				icmp_q  <= icmp_n;
			end
		end
	end

endmodule

// File: rtl/core/ethip_queue.sv
// ----------------------------------------------------------------------------
// ethip_queue
// Small FIFO of frame records between the capture front and the summary back.
// ----------------------------------------------------------------------------
module ethip_queue import ethip_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ethip_rec_t push_rec,
	output logic       full,
	output logic       head_valid,
	output ethip_rec_t head_rec,
	input  logic       pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ethip_rec_t    entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/core/ethip_back.sv
// ----------------------------------------------------------------------------
// ethip_back
// Two-stage summary: length checks and port matches, then class and payload.
// ----------------------------------------------------------------------------
module ethip_back import ethip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  ethip_rec_t head_rec,
	output logic       pop,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	output logic       out_valid,
	input  logic       out_ready,
	output ethip_out_t out_data
);

	typedef struct packed {
		ethip_rec_t  rec;
		logic        short_eth;
		logic        not_ip;
		logic        short_ip;
		logic [15:0] t;
		logic [2:0]  m_dp;
		logic [2:0]  m_sp;
	} ethip_stage_t;

	logic [15:0]  http_q, https_q, dns_q;
	ethip_stage_t st_n, st_s1;
	logic         valid_s1, valid_s2;
	ethip_out_t   res, res_s2;
	logic         adv_s1, adv_s2;
	logic [15:0]  d, sp, dp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			http_q  <= HTTP_PORT_RST;
			https_q <= HTTPS_PORT_RST;
			dns_q   <= DNS_PORT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HTTP_PORT:  http_q  <= cfg_data;
				REG_HTTPS_PORT: https_q <= cfg_data;
				REG_DNS_PORT:   dns_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s2 = !valid_s2 || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = head_valid && adv_s1;

	// stage 1: frame length checks, transport length, port compares
	always_comb begin
		d  = head_rec.len - ETH_HDR_BYTES;
		sp = head_rec.ports[31:16];
		dp = head_rec.ports[15:0];
		st_n.rec       = head_rec;
		st_n.short_eth = (head_rec.len < ETH_HDR_BYTES);
		st_n.not_ip    = (head_rec.ether_kind != ETHERTYPE_IPV4);
		st_n.short_ip  = (d < IPV4_MIN_BYTES) || (d < {10'd0, head_rec.ihl_bytes});
		st_n.t         = d - {10'd0, head_rec.ihl_bytes};
		st_n.m_dp      = {dp == dns_q, dp == https_q, dp == http_q};
		st_n.m_sp      = {sp == dns_q, sp == https_q, sp == http_q};
	end

	always_ff @(posedge clk) begin
		if (pop) st_s1 <= st_n;
	end

	// stage 2: class, transport fields and payload placement
	always_comb begin
		res = '0;
		res.frame_length = st_s1.rec.len;
		priority if (st_s1.short_eth) begin
			res.ok = 1'b0;
		end else if (st_s1.not_ip) begin
			res.ok = 1'b1;
		end else if (st_s1.short_ip) begin
			res.ok = 1'b0;
		end else begin
			res.ok                  = 1'b1;
			res.source_address      = st_s1.rec.src;
			res.destination_address = st_s1.rec.dst;
			res.time_to_live        = st_s1.rec.ttl;
			unique case (st_s1.rec.proto)
				PROTO_TCP: begin
					res.protocol_class = CLS_TCP;
					if (st_s1.t >= TCP_MIN_BYTES) begin
						res.protocol_class   = ethip_classify(st_s1.m_dp, st_s1.m_sp, CLS_TCP);
						res.source_port      = st_s1.rec.ports[31:16];
						res.destination_port = st_s1.rec.ports[15:0];
						res.tcp_flag_bits    = st_s1.rec.flags;
						if (st_s1.t > {10'd0, st_s1.rec.doff_bytes}) begin
							res.payload_offset = ETH_HDR_BYTES + {10'd0, st_s1.rec.ihl_bytes}
								+ {10'd0, st_s1.rec.doff_bytes};
							res.payload_length = st_s1.t - {10'd0, st_s1.rec.doff_bytes};
						end
					end
				end
				PROTO_UDP: begin
					res.protocol_class = CLS_UDP;
					if (st_s1.t >= UDP_HDR_BYTES) begin
						res.protocol_class   = ethip_classify(st_s1.m_dp, st_s1.m_sp, CLS_UDP);
						res.source_port      = st_s1.rec.ports[31:16];
						res.destination_port = st_s1.rec.ports[15:0];
						if (st_s1.t > UDP_HDR_BYTES) begin
							res.payload_offset = ETH_HDR_BYTES + {10'd0, st_s1.rec.ihl_bytes}
								+ UDP_HDR_BYTES;
							res.payload_length = st_s1.t - UDP_HDR_BYTES;
						end
					end
				end
				PROTO_ICMP: begin
					res.protocol_class = CLS_ICMP;
					if (st_s1.t != 16'd0) begin
						priority if (st_s1.rec.icmp_type == ICMP_ECHO_REQ)
							res.icmp_kind = ICMP_REQ;
						else if (st_s1.rec.icmp_type == ICMP_ECHO_REP)
							res.icmp_kind = ICMP_REP;
						else
							res.icmp_kind = ICMP_OTHER;
					end
				end
				default: res.protocol_class = CLS_UNKNOWN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) res_s2 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= head_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

// File: rtl/core/ethernet_ipv4_header_parser_unit.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser_unit
// Ethernet/IPv4/TCP/UDP/ICMP header parser, one frame byte per beat,
// one summary beat per frame.
//
//   channel   direction  payload       handshake
//   in        input      ethip_in_t    in_valid / in_ready
//   out       output     ethip_out_t   out_valid / out_ready
//   cfg       input      16-bit data   cfg_wr_en, cfg_index (no wait)
//
// One byte per cycle sustained; the capture front takes a beat every cycle
// while the record queue has room.
// After the last byte, a summary passes the queue, the check stage and the
// output register.
// in_ready drops only when QUEUE_DEPTH frame records wait behind a stalled
// output; non-final bytes and final bytes are treated alike.
// Reset clears frame state and loads the port registers with 80, 443, 53.
// ----------------------------------------------------------------------------
module ethernet_ipv4_header_parser_unit import ethip_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ethip_in_t   in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output ethip_out_t  out_data,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic       accept, push, full, head_valid, pop;
	ethip_rec_t push_rec, head_rec;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	ethip_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.beat     (in_data),
		.push     (push),
		.push_rec (push_rec)
	);

	ethip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (full),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop)
	);

	ethip_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// File: rtl/core/ethip_checker.sv
// ----------------------------------------------------------------------------
// ethip_checker
// Port-level checks on the summary channel of the header parser.
// ----------------------------------------------------------------------------
module ethip_checker import ethip_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input ethip_out_t out_data
);

	// a stalled summary beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("summary beat changed while stalled");

	// too-short frames carry nothing but their length
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.protocol_class == CLS_UNKNOWN
			&& out_data.source_address == '0 && out_data.payload_length == '0)
		else $error("short frame with header fields");

	// icmp kind only on ICMP frames
	a_icmp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.protocol_class != CLS_ICMP |-> out_data.icmp_kind == ICMP_NONE)
		else $error("icmp kind on non-ICMP frame");

	// payload runs exactly to the end of the frame
	a_payload_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.payload_length != '0 |->
			out_data.payload_offset + out_data.payload_length == out_data.frame_length)
		else $error("payload does not end at frame end");

endmodule

bind ethernet_ipv4_header_parser_unit ethip_checker u_ethip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: bench/ethernet_ipv4_header_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser_unit_tb
// Streams Ethernet frames into the parser one byte per beat and checks every
// frame summary against a cycle-free predictor of the header capture. A
// directed set covers short, non-IPv4, odd IHL, port priority and ICMP kinds.
// Random phases follow under varied port registers and handshake pressure.
// ----------------------------------------------------------------------------
module ethernet_ipv4_header_parser_unit_tb;
	import ethip_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	ethip_in_t   in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	ethip_out_t  out_data;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = REG_HTTP_PORT;
	logic [15:0] cfg_data = '0;

	ethernet_ipv4_header_parser_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// bench copy of the port registers
	logic [15:0] http_port_cfg  = HTTP_PORT_RST;
	logic [15:0] https_port_cfg = HTTPS_PORT_RST;
	logic [15:0] dns_port_cfg   = DNS_PORT_RST;

	// per-frame capture state of the predictor
	logic [15:0] frame_pos = '0;
	logic [15:0] frame_etype = '0;
	logic [5:0]  ihl_bytes = '0;
	logic [7:0]  cap_proto = '0;
	logic [7:0]  cap_ttl = '0;
	logic [31:0] cap_src = '0;
	logic [31:0] cap_dst = '0;
	logic [31:0] cap_ports = '0;
	logic [5:0]  doff_bytes = '0;
	logic [7:0]  cap_flags = '0;
	logic [7:0]  cap_icmp_type = '0;

	ethip_in_t   byte_queue[$];
	ethip_out_t  summary_queue[$];

	int          in_idle_pct = 0;
	int          out_stall_pct = 0;
	bit          beat_taken = 1'b0;
	bit          drained = 1'b0;
	int unsigned error_count = 0;
	int unsigned frames_seen = 0;
	int unsigned bytes_sent = 0;
	int unsigned settings_used = 1;
	int unsigned cycle_count = 0;

	function automatic ethip_class_t port_match(input logic [15:0] p);
		if (p == http_port_cfg) return CLS_HTTP;
		if (p == https_port_cfg) return CLS_HTTPS;
		if (p == dns_port_cfg) return CLS_DNS;
		return CLS_UNKNOWN;
	endfunction

	// destination port has priority over source port
	function automatic ethip_class_t classify_ports(input logic [15:0] sp, input logic [15:0] dp,
			input ethip_class_t fallback);
		ethip_class_t c;
		c = port_match(dp);
		if (c == CLS_UNKNOWN) c = port_match(sp);
		if (c == CLS_UNKNOWN) c = fallback;
		return c;
	endfunction

	task automatic predict_beat(input ethip_in_t beat);
		logic [7:0]  b;
		int unsigned pos, ihl_now, len, d, t, ti;
		logic [15:0] sp, dp;
		ethip_out_t  want;
		b = beat.data_byte;
		pos = 32'(frame_pos);
		if (pos == POS_ETYPE_HI) frame_etype[15:8] = b;
		if (pos == POS_ETYPE_LO) frame_etype[7:0] = b;
		if (pos == POS_IHL) ihl_bytes = {b[3:0], 2'b00};
		if (pos == POS_TTL) cap_ttl = b;
		if (pos == POS_PROTO) cap_proto = b;
		if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) cap_src = {cap_src[23:0], b};
		if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) cap_dst = {cap_dst[23:0], b};
		// IHL is live from its own byte on, so IHL 0 starts transport at byte 14
		ihl_now = 32'(ihl_bytes);
		if (pos >= ETH_HDR_BYTES + ihl_now) begin
			ti = pos - ETH_HDR_BYTES - ihl_now;
			if (ti == 0) cap_icmp_type = b;
			if (ti < TI_PORTS_END) cap_ports = {cap_ports[23:0], b};
			if (ti == TI_DOFF) doff_bytes = {b[7:4], 2'b00};
			if (ti == TI_FLAGS) cap_flags = b;
		end
		len = (pos >= POS_MAX) ? POS_MAX : pos + 1;
		if (frame_pos != POS_MAX) frame_pos++;

		if (beat.last_byte) begin
			want = '0;
			want.frame_length = 16'(len);
			if (len >= ETH_HDR_BYTES) begin
				d = len - ETH_HDR_BYTES;
				if (frame_etype != ETHERTYPE_IPV4) begin
					want.ok = 1'b1;
				end else if (d >= IPV4_MIN_BYTES && d >= ihl_now) begin
					want.ok = 1'b1;
					want.source_address = cap_src;
					want.destination_address = cap_dst;
					want.time_to_live = cap_ttl;
					t = d - ihl_now;
					sp = cap_ports[31:16];
					dp = cap_ports[15:0];
					case (cap_proto)
					PROTO_TCP: begin
						want.protocol_class = CLS_TCP;
						if (t >= TCP_MIN_BYTES) begin
							want.protocol_class = classify_ports(sp, dp, CLS_TCP);
							want.source_port = sp;
							want.destination_port = dp;
							want.tcp_flag_bits = cap_flags[4:0];
							if (t > doff_bytes) begin
								want.payload_offset = 16'(ETH_HDR_BYTES + ihl_now + doff_bytes);
								want.payload_length = 16'(t - doff_bytes);
							end
						end
					end
					PROTO_UDP: begin
						want.protocol_class = CLS_UDP;
						if (t >= UDP_HDR_BYTES) begin
							want.protocol_class = classify_ports(sp, dp, CLS_UDP);
							want.source_port = sp;
							want.destination_port = dp;
							if (t > UDP_HDR_BYTES) begin
								want.payload_offset = 16'(ETH_HDR_BYTES + ihl_now + UDP_HDR_BYTES);
								want.payload_length = 16'(t - UDP_HDR_BYTES);
							end
						end
					end
					PROTO_ICMP: begin
						want.protocol_class = CLS_ICMP;
						if (t >= 1) begin
							case (cap_icmp_type)
							ICMP_ECHO_REQ: want.icmp_kind = ICMP_REQ;
							ICMP_ECHO_REP: want.icmp_kind = ICMP_REP;
							default:       want.icmp_kind = ICMP_OTHER;
							endcase
						end
					end
					default: want.protocol_class = CLS_UNKNOWN;
					endcase
				end
			end
			summary_queue.push_back(want);
			frame_pos = '0;
			frame_etype = '0;
			ihl_bytes = '0;
			cap_proto = '0;
			cap_ttl = '0;
			cap_src = '0;
			cap_dst = '0;
			cap_ports = '0;
			doff_bytes = '0;
			cap_flags = '0;
			cap_icmp_type = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("frame %0d: %s got 0x%0h, expected 0x%0h", frames_seen, what, got, want);
		error_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	// random bytes with the header fields laid over them; IP fields go last
	// so that a small IHL keeps the chosen IHL and protocol bytes
	task automatic push_frame(input int unsigned len, input logic [15:0] etype,
			input logic [3:0] ihl, input logic [7:0] proto, input logic [15:0] sp,
			input logic [15:0] dp, input logic [3:0] doff, input logic [7:0] flags);
		int unsigned ts;
		logic [7:0]  b;
		ts = ETH_HDR_BYTES + 4 * ihl;
		for (int unsigned i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == ts) b = sp[15:8];
			if (i == ts + 1) b = sp[7:0];
			if (i == ts + 2) b = dp[15:8];
			if (i == ts + 3) b = dp[7:0];
			if (i == ts + TI_DOFF) b[7:4] = doff;
			if (i == ts + TI_FLAGS) b = flags;
			if (i == POS_ETYPE_HI) b = etype[15:8];
			if (i == POS_ETYPE_LO) b = etype[7:0];
			if (i == POS_IHL) b[3:0] = ihl;
			if (i == POS_PROTO) b = proto;
			byte_queue.push_back('{data_byte: b, last_byte: (i == len - 1)});
		end
	endtask

	function automatic logic [15:0] pick_port();
		case ($urandom_range(7))
		0: return http_port_cfg;
		1: return https_port_cfg;
		2: return dns_port_cfg;
		3: return 16'h0000;
		4: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_random_frame(output int unsigned frame_len);
		int unsigned pick, ihl, doff, t;
		logic [15:0] etype, sp, dp;
		logic [7:0]  proto;
		pick = $urandom_range(99);
		case ($urandom_range(19))
		0, 1:    ihl = $urandom_range(4);
		2, 3, 4: ihl = $urandom_range(15, 6);
		default: ihl = 5;
		endcase
		case ($urandom_range(19))
		0, 1:    doff = $urandom_range(4);
		2, 3, 4: doff = $urandom_range(15, 6);
		default: doff = 5;
		endcase
		sp = pick_port();
		dp = pick_port();
		case ($urandom_range(9))
		0, 1, 2: begin
			proto = PROTO_TCP;
			t = ((4 * doff > TCP_MIN_BYTES) ? 4 * doff : TCP_MIN_BYTES) + $urandom_range(12);
		end
		3, 4, 5: begin
			proto = PROTO_UDP;
			t = UDP_HDR_BYTES + $urandom_range(12);
		end
		6, 7: begin
			proto = PROTO_ICMP;
			t = $urandom_range(12);
			case ($urandom_range(2))
			0: sp[15:8] = ICMP_ECHO_REQ;
			1: sp[15:8] = ICMP_ECHO_REP;
			default: sp[15:8] = 8'($urandom);
			endcase
		end
		default: begin
			proto = 8'($urandom);
			t = $urandom_range(12);
		end
		endcase
		etype = ETHERTYPE_IPV4;
		frame_len = ETH_HDR_BYTES + 4 * ihl + t;
		if (pick < 8) begin
			// noise
			frame_len = $urandom_range(40, 1);
			etype = 16'($urandom);
		end else if (pick < 16) begin
			case ($urandom_range(5))
			0: etype = 16'h0806;
			1: etype = 16'h86DD;
			2: etype = 16'h0801;
			3: etype = 16'h0000;
			4: etype = 16'hFFFF;
			default: etype = 16'($urandom);
			endcase
			if (etype == ETHERTYPE_IPV4) etype = 16'h0900;
		end else if (pick < 24) begin
			frame_len = $urandom_range(frame_len, 1);
		end
		push_frame(frame_len, etype, ihl[3:0], proto, sp, dp, doff[3:0], 8'($urandom));
	endtask

	// returns on a rising edge, once nothing is queued, in flight or expected
	task automatic wait_idle();
		do @(posedge clk); while (!drained);
	endtask

	task automatic write_ports(input logic [15:0] h, input logic [15:0] s, input logic [15:0] d);
		wait_idle();
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_HTTP_PORT;
		cfg_data <= h;
		http_port_cfg = h;
		@(negedge clk);
		cfg_index <= REG_HTTPS_PORT;
		cfg_data <= s;
		https_port_cfg = s;
		@(negedge clk);
		cfg_index <= REG_DNS_PORT;
		cfg_data <= d;
		dns_port_cfg = d;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic random_phase(input int in_idle, input int out_stall, input logic [15:0] h,
			input logic [15:0] s, input logic [15:0] d, input bit pause_midway);
		int unsigned frames, bytes, flen;
		write_ports(h, s, d);
		in_idle_pct = in_idle;
		out_stall_pct = out_stall;
		frames = 0;
		bytes = 0;
		while (frames < 2 || bytes < 100) begin
			queue_random_frame(flen);
			frames++;
			bytes += flen;
			if (pause_midway && frames == 1) wait_idle();
		end
	endtask

	// sender: a beat is held until taken
	always @(negedge clk) begin : driver
		bit presenting;
		presenting = in_valid;
		if (arst_n && (!in_valid || beat_taken)) begin
			beat_taken = 1'b0;
			presenting = (byte_queue.size() != 0) && ($urandom_range(99) >= in_idle_pct);
			if (presenting) in_data <= byte_queue.pop_front();
			in_valid <= presenting;
		end
		drained <= !presenting && byte_queue.size() == 0 && summary_queue.size() == 0;
	end

	always @(negedge clk) out_ready <= ($urandom_range(99) >= out_stall_pct);

	always @(posedge clk) begin : monitor
		ethip_out_t want;
		if (arst_n && in_valid && in_ready) begin
			predict_beat(in_data);
			beat_taken = 1'b1;
			bytes_sent++;
		end
		if (arst_n && out_valid && out_ready) begin
			frames_seen++;
			if (summary_queue.size() == 0) begin
				report_mismatch("summary with nothing expected", 1, 0);
			end else begin
				want = summary_queue.pop_front();
				check_field("ok", out_data.ok, want.ok);
				check_field("protocol_class", out_data.protocol_class, want.protocol_class);
				check_field("source_address", out_data.source_address, want.source_address);
				check_field("destination_address", out_data.destination_address,
					want.destination_address);
				check_field("time_to_live", out_data.time_to_live, want.time_to_live);
				check_field("source_port", out_data.source_port, want.source_port);
				check_field("destination_port", out_data.destination_port, want.destination_port);
				check_field("tcp_flag_bits", out_data.tcp_flag_bits, want.tcp_flag_bits);
				check_field("icmp_kind", out_data.icmp_kind, want.icmp_kind);
				check_field("frame_length", out_data.frame_length, want.frame_length);
				check_field("payload_offset", out_data.payload_offset, want.payload_offset);
				check_field("payload_length", out_data.payload_length, want.payload_length);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout: %0d summaries still pending after %0d cycles",
				summary_queue.size(), cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed frames, reset port registers, no idling
		push_frame(1, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 16'd80, 4'd5, 8'hFF);
		push_frame(13, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 16'd80, 4'd5, 8'hFF);
		push_frame(14, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 16'd80, 4'd5, 8'hFF);
		push_frame(14, 16'h86DD, 4'd5, PROTO_TCP, 16'd80, 16'd80, 4'd5, 8'hFF);
		push_frame(33, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 16'd80, 4'd5, 8'hFF);
		push_frame(34, ETHERTYPE_IPV4, 4'd5, 8'hFF, 16'd80, 16'd80, 4'd5, 8'hFF);
		// IHL 15 but frame ends inside the options
		push_frame(40, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 16'd1234, 16'd80, 4'd5, 8'h00);
		// transport overlaps the IPv4 header
		push_frame(54, ETHERTYPE_IPV4, 4'd0, PROTO_TCP, 16'h10BB, 16'd9999, 4'd5, 8'h12);
		push_frame(58, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 16'd53, 4'd5, 8'h10);
		push_frame(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000, 16'hFFFF, 4'd5, 8'h00);
		push_frame(34, ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, 16'h0800, 16'd0, 4'd5, 8'h00);
		push_frame(35, ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, {ICMP_ECHO_REQ, 8'h00}, 16'd0, 4'd5,
			8'h00);

		random_phase(0, 0, 16'h0000, 16'hFFFF, 16'h8000, 1'b0);
		random_phase(54, 0, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
		random_phase(0, 54, 16'd8080, 16'd8080, 16'd8080, 1'b0);
		random_phase(7, 7, 16'($urandom), 16'($urandom), 16'hFFFF, 1'b0);

		wait_idle();
		repeat (12) @(posedge clk);
		if (summary_queue.size() != 0)
			report_mismatch("summaries never delivered", summary_queue.size(), 0);
		$display("Checked %0d frame summaries from %0d bytes under %0d port register settings",
			frames_seen, bytes_sent, settings_used);
		$display("covering short, non-IPv4, TCP/UDP/ICMP, odd IHL and offsets, stalls");
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
